[design/lstg_pkg.sv]
// ----------------------------------------------------------------------------
// lstg_pkg: shared types and constants for the lidar beam to grid cell path
// Field widths, register codes, the configuration bundle, the stage payloads
// and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package lstg_pkg;

	localparam int BEAM_W     = 11;
	localparam int RANGE_W    = 16;
	localparam int CELL_W     = 10;
	localparam int ANG_W      = 16;
	localparam int TRIG_W     = 16;
	localparam int POSE_W     = 24;
	localparam int SCALE_W    = 24;
	localparam int ORG_W      = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam int MAP_WIDTH  = 1024;
	localparam int MAP_HEIGHT = 1024;
	localparam int MAX_BEAMS  = 2048;

	// a quarter turn in binary angle units
	localparam logic [ANG_W-1:0] QUARTER = 16'd16384;

	localparam logic signed [POSE_W-1:0] POSE_X_RST    = '0;
	localparam logic signed [POSE_W-1:0] POSE_Y_RST    = '0;
	localparam logic [ANG_W-1:0]         HEADING_RST   = 16'd0;
	localparam logic [ANG_W-1:0]         ANG_BASE_RST  = 16'd0;
	localparam logic [ANG_W-1:0]         ANG_PITCH_RST = 16'd182;
	localparam logic [SCALE_W-1:0]       CELL_SCALE_RST = 24'd335544;
	localparam logic signed [ORG_W-1:0]  ORIGIN_X_RST  = 16'sd512;
	localparam logic signed [ORG_W-1:0]  ORIGIN_Y_RST  = 16'sd512;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POSE_X     = 4'd0,
		REG_POSE_Y     = 4'd1,
		REG_HEADING    = 4'd2,
		REG_ANG_BASE   = 4'd3,
		REG_ANG_PITCH  = 4'd4,
		REG_CELL_SCALE = 4'd5,
		REG_ORIGIN_X   = 4'd6,
		REG_ORIGIN_Y   = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [POSE_W-1:0] pose_x;
		logic signed [POSE_W-1:0] pose_y;
		logic [ANG_W-1:0]         heading;
		logic [ANG_W-1:0]         ang_base;
		logic [ANG_W-1:0]         ang_pitch;
		logic [SCALE_W-1:0]       cell_scale;
		logic signed [ORG_W-1:0]  origin_x;
		logic signed [ORG_W-1:0]  origin_y;
	} cfg_t;

	typedef struct packed {
		logic [RANGE_W-1:0] range_mm;
		logic [ANG_W-1:0]   ang;
	} ang_pl_t;

	typedef struct packed {
		logic [RANGE_W-1:0]        range_mm;
		logic signed [TRIG_W-1:0]  cos_v;
		logic signed [TRIG_W-1:0]  sin_v;
	} sc_pl_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
	} cell_pl_t;

	// sine over the first quadrant, 65 points, Q1.15 magnitude
	function automatic logic [14:0] quarter_sine(input logic [6:0] i);
		logic [14:0] v;
		case (i)
			7'd0:  v = 15'd0;     7'd1:  v = 15'd804;   7'd2:  v = 15'd1608;
			7'd3:  v = 15'd2410;  7'd4:  v = 15'd3212;  7'd5:  v = 15'd4011;
			7'd6:  v = 15'd4808;  7'd7:  v = 15'd5602;  7'd8:  v = 15'd6393;
			7'd9:  v = 15'd7179;  7'd10: v = 15'd7962;  7'd11: v = 15'd8739;
			7'd12: v = 15'd9512;  7'd13: v = 15'd10278; 7'd14: v = 15'd11039;
			7'd15: v = 15'd11793; 7'd16: v = 15'd12539; 7'd17: v = 15'd13279;
			7'd18: v = 15'd14010; 7'd19: v = 15'd14732; 7'd20: v = 15'd15446;
			7'd21: v = 15'd16151; 7'd22: v = 15'd16846; 7'd23: v = 15'd17530;
			7'd24: v = 15'd18204; 7'd25: v = 15'd18868; 7'd26: v = 15'd19519;
			7'd27: v = 15'd20159; 7'd28: v = 15'd20787; 7'd29: v = 15'd21403;
			7'd30: v = 15'd22005; 7'd31: v = 15'd22594; 7'd32: v = 15'd23170;
			7'd33: v = 15'd23731; 7'd34: v = 15'd24279; 7'd35: v = 15'd24811;
			7'd36: v = 15'd25329; 7'd37: v = 15'd25832; 7'd38: v = 15'd26319;
			7'd39: v = 15'd26790; 7'd40: v = 15'd27245; 7'd41: v = 15'd27683;
			7'd42: v = 15'd28105; 7'd43: v = 15'd28510; 7'd44: v = 15'd28898;
			7'd45: v = 15'd29268; 7'd46: v = 15'd29621; 7'd47: v = 15'd29956;
			7'd48: v = 15'd30273; 7'd49: v = 15'd30571; 7'd50: v = 15'd30852;
			7'd51: v = 15'd31113; 7'd52: v = 15'd31356; 7'd53: v = 15'd31580;
			7'd54: v = 15'd31785; 7'd55: v = 15'd31971; 7'd56: v = 15'd32137;
			7'd57: v = 15'd32285; 7'd58: v = 15'd32412; 7'd59: v = 15'd32521;
			7'd60: v = 15'd32609; 7'd61: v = 15'd32678; 7'd62: v = 15'd32728;
			7'd63: v = 15'd32757;
			default: v = 15'd32767;
		endcase
		return v;
	endfunction

endpackage

[design/lstg_ifs.sv]
// ----------------------------------------------------------------------------
// lstg_ifs: valid/ready channels of the lidar beam to grid cell block
// Beam input, cell output and register write channels.
// ----------------------------------------------------------------------------
interface lstg_beam_if
	import lstg_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [BEAM_W-1:0]  beam_index;
	logic [RANGE_W-1:0] range_mm;

	modport source(output valid, beam_index, range_mm, input ready);
	modport sink(input valid, beam_index, range_mm, output ready);
endinterface

interface lstg_cell_if
	import lstg_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_x;
	logic [CELL_W-1:0] cell_y;

	modport source(output valid, cell_x, cell_y, input ready);
	modport sink(input valid, cell_x, cell_y, output ready);
endinterface

interface lstg_cfg_if
	import lstg_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[design/lstg_cfg.sv]
// ----------------------------------------------------------------------------
// lstg_cfg: configuration register file
// Takes one register write per beat; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lstg_cfg
	import lstg_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	lstg_cfg_if.sink cfg,
	output cfg_t   regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pose_x     <= POSE_X_RST;
			regs_q.pose_y     <= POSE_Y_RST;
			regs_q.heading    <= HEADING_RST;
			regs_q.ang_base   <= ANG_BASE_RST;
			regs_q.ang_pitch  <= ANG_PITCH_RST;
			regs_q.cell_scale <= CELL_SCALE_RST;
			regs_q.origin_x   <= ORIGIN_X_RST;
			regs_q.origin_y   <= ORIGIN_Y_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_POSE_X:     regs_q.pose_x     <= cfg.data[POSE_W-1:0];
				REG_POSE_Y:     regs_q.pose_y     <= cfg.data[POSE_W-1:0];
				REG_HEADING:    regs_q.heading    <= cfg.data[ANG_W-1:0];
				REG_ANG_BASE:   regs_q.ang_base   <= cfg.data[ANG_W-1:0];
				REG_ANG_PITCH:  regs_q.ang_pitch  <= cfg.data[ANG_W-1:0];
				REG_CELL_SCALE: regs_q.cell_scale <= cfg.data[SCALE_W-1:0];
				REG_ORIGIN_X:   regs_q.origin_x   <= cfg.data[ORG_W-1:0];
				REG_ORIGIN_Y:   regs_q.origin_y   <= cfg.data[ORG_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[design/lstg_sincos.sv]
// ----------------------------------------------------------------------------
// lstg_sincos: two-stage cosine/sine generator
// Stage 2 folds the angle into the first quadrant and reads the table;
// stage 3 interpolates between table points and applies the sign.
// ----------------------------------------------------------------------------
module lstg_sincos
	import lstg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_vld,
	input  ang_pl_t in_pl,
	output logic    in_rdy,
	output logic    out_vld,
	output sc_pl_t  out_pl,
	input  logic    out_rdy
);

	typedef struct packed {
		logic [14:0] base;
		logic [9:0]  diff;
		logic [7:0]  frac;
		logic        neg;
	} lk_t;

	function automatic lk_t sine_lookup(input logic [ANG_W-1:0] a);
		logic [14:0] u;
		logic [6:0]  i;
		logic [14:0] t0;
		logic [14:0] t1;
		lk_t         r;
		u  = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
		i  = u[14:8];
		t0 = quarter_sine(i);
		t1 = quarter_sine(i + 7'd1);
		r.neg  = a[15];
		r.frac = u[7:0];
		// top of the quadrant saturates at the table end
		if (i[6]) begin
			r.base = 15'd32767;
			r.diff = '0;
		end else begin
			r.base = t0;
			r.diff = 10'(t1 - t0);
		end
		return r;
	endfunction

	function automatic logic signed [TRIG_W-1:0] interp(input lk_t k);
		logic [17:0] prod;
		logic [14:0] mag;
		prod = 18'(k.diff) * 18'(k.frac);
		mag  = k.base + 15'(prod >> 8);
		return k.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	logic                     vld_s2, vld_s3;
	logic                     rdy_s2, rdy_s3;
	logic [RANGE_W-1:0]       range_s2;
	lk_t                      cos_lk_s2, sin_lk_s2;
	sc_pl_t                   pl_s3;

	assign rdy_s3 = !vld_s3 || out_rdy;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign in_rdy = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s2) vld_s2 <= in_vld;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_vld) begin
			range_s2  <= in_pl.range_mm;
			cos_lk_s2 <= sine_lookup(in_pl.ang + QUARTER);
			sin_lk_s2 <= sine_lookup(in_pl.ang);
		end
		if (rdy_s3 && vld_s2) begin
			pl_s3.range_mm <= range_s2;
			pl_s3.cos_v    <= interp(cos_lk_s2);
			pl_s3.sin_v    <= interp(sin_lk_s2);
		end
	end

	assign out_vld = vld_s3;
	assign out_pl  = pl_s3;

`ifndef SYNTH
	a_trig_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (pl_s3.cos_v != -16'sd32768 && pl_s3.sin_v != -16'sd32768))
		else $error("trig value outside Q1.15 magnitude");
	a_sat_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && sin_lk_s2.base == 15'd32767) |-> sin_lk_s2.diff == 10'd0)
		else $error("saturated sine carries a nonzero slope");
`endif

endmodule

[design/lstg_project.sv]
// ----------------------------------------------------------------------------
// lstg_project: polar to grid projection pipeline
// Stage 4 multiplies range by cos/sin, stage 5 adds the pose, stage 6 scales
// to cells, stage 7 truncates, adds the origin and drops hits off the map.
// ----------------------------------------------------------------------------
module lstg_project
	import lstg_pkg::*;
#(
	parameter int GRID_W = MAP_WIDTH,
	parameter int GRID_H = MAP_HEIGHT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     regs,
	input  logic     in_vld,
	input  sc_pl_t   in_pl,
	output logic     in_rdy,
	output logic     out_vld,
	output cell_pl_t out_pl,
	input  logic     out_rdy
);

	logic vld_s4, vld_s5, vld_s6, vld_s7;
	logic rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	logic signed [32:0] px_s4, py_s4;
	logic signed [24:0] xmm_s5;
	logic signed [25:0] nymm_s5;
	logic signed [49:0] xs_s6;
	logic signed [50:0] ys_s6;
	cell_pl_t           pl_s7;

	logic signed [24:0] xmm_nxt, ymm_nxt;
	logic signed [49:0] xs_adj;
	logic signed [50:0] ys_adj;
	logic signed [26:0] cx_nxt;
	logic signed [27:0] cy_nxt;
	logic               on_map;

	assign rdy_s7 = !vld_s7 || out_rdy;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign in_rdy = rdy_s4;

	always_comb begin
		xmm_nxt = 25'(px_s4 >>> 15) + 25'(regs.pose_x);
		ymm_nxt = 25'(py_s4 >>> 15) + 25'(regs.pose_y);
		// round toward zero: bias negative products before the shift
		xs_adj  = xs_s6 + $signed({26'd0, {24{xs_s6[49]}}});
		ys_adj  = ys_s6 + $signed({27'd0, {24{ys_s6[50]}}});
		cx_nxt  = 27'(xs_adj >>> 24) + 27'(regs.origin_x);
		cy_nxt  = 28'(ys_adj >>> 24) + 28'(regs.origin_y);
		on_map  = (cx_nxt >= 0) && (cx_nxt < GRID_W) &&
			(cy_nxt >= 0) && (cy_nxt < GRID_H);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy_s4) vld_s4 <= in_vld;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			// drop hits that fall off the map
			if (rdy_s7) vld_s7 <= vld_s6 && on_map;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_vld) begin
			px_s4 <= $signed({1'b0, in_pl.range_mm}) * in_pl.cos_v;
			py_s4 <= $signed({1'b0, in_pl.range_mm}) * in_pl.sin_v;
		end
		if (rdy_s5 && vld_s4) begin
			xmm_s5  <= xmm_nxt;
			nymm_s5 <= -(26'(ymm_nxt));
		end
		if (rdy_s6 && vld_s5) begin
			xs_s6 <= xmm_s5 * $signed({1'b0, regs.cell_scale});
			ys_s6 <= nymm_s5 * $signed({1'b0, regs.cell_scale});
		end
		if (rdy_s7 && vld_s6) begin
			pl_s7.cell_x <= cx_nxt[CELL_W-1:0];
			pl_s7.cell_y <= cy_nxt[CELL_W-1:0];
		end
	end

	assign out_vld = vld_s7;
	assign out_pl  = pl_s7;

`ifndef SYNTH
	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !rdy_s6) |=> vld_s5)
		else $error("stage 5 lost a beam under stall");
`endif

endmodule

[design/lidar_scan_to_grid_cell.sv]
// ----------------------------------------------------------------------------
// lidar_scan_to_grid_cell: project one lidar beam into an occupancy-grid cell
//
//   channel | dir | beat carries            | notes
//   --------+-----+-------------------------+------------------------------
//   beam    | in  | beam_index, range_mm    | one beam per beat
//   grid    | out | cell_x, cell_y          | zero or one beat per beam
//   cfg     | in  | index, data             | register write, always ready
//
// Seven register stages: angle, table read, interpolation, range multiply,
// pose add, scale multiply, truncate/origin/map check. A beam enters every
// cycle unless the grid side holds back. Every stage stalls on its
// own, so bubbles (beams that miss the map) close up under back-pressure.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module lidar_scan_to_grid_cell
	import lstg_pkg::*;
#(
	parameter int GRID_W = MAP_WIDTH,
	parameter int GRID_H = MAP_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	lstg_beam_if.sink   beam,
	lstg_cell_if.source grid,
	lstg_cfg_if.sink    cfg
);

	cfg_t               regs;
	logic               vld_s1, rdy_s1;
	ang_pl_t            pl_s1;
	logic               sc_rdy, sc_vld;
	sc_pl_t             sc_pl;
	logic               prj_rdy;
	cell_pl_t           cell_pl;
	logic [BEAM_W-1:0]  beam_mod;
	logic [26:0]        beam_prod;
	logic [ANG_W-1:0]   ang_nxt;

	lstg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// stage 1: beam angle, wrapped to one turn
	assign beam_mod  = BEAM_W'(32'(beam.beam_index) % MAX_BEAMS);
	assign beam_prod = 27'(beam_mod) * 27'(regs.ang_pitch);
	assign ang_nxt   = regs.ang_base + beam_prod[ANG_W-1:0] + regs.heading;

	assign rdy_s1     = !vld_s1 || sc_rdy;
	assign beam.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= beam.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && beam.valid) begin
			pl_s1.range_mm <= beam.range_mm;
			pl_s1.ang      <= ang_nxt;
		end
	end

	lstg_sincos u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.in_pl   (pl_s1),
		.in_rdy  (sc_rdy),
		.out_vld (sc_vld),
		.out_pl  (sc_pl),
		.out_rdy (prj_rdy)
	);

	lstg_project #(
		.GRID_W (GRID_W),
		.GRID_H (GRID_H)
	) u_project (
		.clk     (clk),
		.arst_n  (arst_n),
		.regs    (regs),
		.in_vld  (sc_vld),
		.in_pl   (sc_pl),
		.in_rdy  (prj_rdy),
		.out_vld (grid.valid),
		.out_pl  (cell_pl),
		.out_rdy (grid.ready)
	);

	assign grid.cell_x = cell_pl.cell_x;
	assign grid.cell_y = cell_pl.cell_y;

`ifndef SYNTH
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!grid.valid |-> beam.ready)
		else $error("input stalled with an empty output register");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(beam.valid && beam.ready) |=> vld_s1)
		else $error("accepted beam missing from stage 1");
`endif

endmodule

[test/lidar_scan_to_grid_cell_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_to_grid_cell_tb: beam to grid cell projection check
// Drives beams through the valid/ready input while the output side stalls at
// random. Every beam is projected here with an independent integer model of
// the angle, sine table, pose, scale and map bounds, and each delivered cell
// is matched in order against the cells that model says should come out.
// Register settings run from the reset values through random geometries to
// the extremes of every register.
// ----------------------------------------------------------------------------
module lidar_scan_to_grid_cell_tb;
	import lstg_pkg::*;

	localparam int      DRAIN_CYCLES  = 16;
	localparam int      END_WAIT      = 20000;
	localparam int      PHASE_BEAMS   = 70;
	localparam int      RANDOM_PHASES = 9;
	localparam int      FIRST_SPARE_REG = 8;
	localparam int      LAST_SPARE_REG  = 15;
	localparam longint  CELL_ONE      = 64'sd16777216;

	// quarter-wave sine, Q1.15, 256 angle units between points
	localparam int SINE_Q [65] = '{
		0, 804, 1608, 2410, 3212, 4011, 4808, 5602,
		6393, 7179, 7962, 8739, 9512, 10278, 11039, 11793,
		12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
		18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
		23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
		27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
		30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
		32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
		32767
	};

	logic clk;
	logic arst_n;

	lstg_beam_if beam_ch ();
	lstg_cell_if cell_ch ();
	lstg_cfg_if  cfg_ch ();

	lidar_scan_to_grid_cell i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.beam   (beam_ch),
		.grid   (cell_ch),
		.cfg    (cfg_ch)
	);

	// geometry as the block should hold it
	longint             m_pose_x, m_pose_y, m_org_x, m_org_y;
	logic [ANG_W-1:0]   m_heading, m_start, m_step;
	logic [SCALE_W-1:0] m_scale;

	cell_pl_t cells_due [$];
	cell_pl_t want_cell;
	bit       calm;
	int       n_beams, n_missed, n_cells, n_writes, n_errors;
	logic [BEAM_W-1:0] scan_pos;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int quadrant_sine(input int u);
		int i;
		int f;
		i = u >> 8;
		f = u & 255;
		if (i >= 64)
			return SINE_Q[64];
		return SINE_Q[i] + (((SINE_Q[i+1] - SINE_Q[i]) * f) >> 8);
	endfunction

	function automatic int angle_sine(input logic [ANG_W-1:0] a);
		int p;
		int v;
		p = int'(a[13:0]);
		v = a[14] ? quadrant_sine(16384 - p) : quadrant_sine(p);
		return a[15] ? -v : v;
	endfunction

	function automatic void reset_geometry();
		m_pose_x  = 0;
		m_pose_y  = 0;
		m_heading = '0;
		m_start   = '0;
		m_step    = 16'd182;
		m_scale   = 24'd335544;
		m_org_x   = 512;
		m_org_y   = 512;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] v);
		case (idx)
			REG_POSE_X:     m_pose_x  = longint'($signed(v));
			REG_POSE_Y:     m_pose_y  = longint'($signed(v));
			REG_HEADING:    m_heading = v[15:0];
			REG_ANG_BASE:   m_start   = v[15:0];
			REG_ANG_PITCH:  m_step    = v[15:0];
			REG_CELL_SCALE: m_scale   = v;
			REG_ORIGIN_X:   m_org_x   = longint'($signed(v[15:0]));
			REG_ORIGIN_Y:   m_org_y   = longint'($signed(v[15:0]));
			default: ;
		endcase
	endfunction

	// returns 0 when the hit point falls off the map
	function automatic bit project_beam(input logic [BEAM_W-1:0] idx,
		input logic [RANGE_W-1:0] rng, output cell_pl_t hit);
		logic [ANG_W-1:0] ang;
		logic [ANG_W-1:0] cos_ang;
		longint xm, ym, cx, cy;
		ang     = m_start + idx * m_step + m_heading;
		cos_ang = ang + QUARTER;
		xm = ((longint'(rng) * angle_sine(cos_ang)) >>> 15) + m_pose_x;
		ym = ((longint'(rng) * angle_sine(ang)) >>> 15) + m_pose_y;
		// signed division truncates toward zero
		cx = (xm * longint'(m_scale)) / CELL_ONE + m_org_x;
		cy = (-ym * longint'(m_scale)) / CELL_ONE + m_org_y;
		hit.cell_x = cx[CELL_W-1:0];
		hit.cell_y = cy[CELL_W-1:0];
		return cx >= 0 && cx < MAP_WIDTH && cy >= 0 && cy < MAP_HEIGHT;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		$display("mismatch @%0t: %s: got %0d, want %0d", $time, what, got, want);
	endtask

	task automatic beam_idle();
		@(negedge clk);
		beam_ch.valid <= 1'b0;
	endtask

	task automatic send_beam(input logic [BEAM_W-1:0] idx, input logic [RANGE_W-1:0] rng);
		int       gap;
		cell_pl_t hit;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			beam_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		beam_ch.valid      <= 1'b1;
		beam_ch.beam_index <= idx;
		beam_ch.range_mm   <= rng;
		do @(posedge clk); while (!beam_ch.ready);
		n_beams++;
		if (project_beam(idx, rng, hit))
			cells_due.insert(cells_due.size(), hit);
		else
			n_missed++;
	endtask

	// hold the sender until every due cell is out
	task automatic wait_cells_out();
		beam_idle();
		while (cells_due.size() != 0) @(posedge clk);
	endtask

	// beams that miss the map may still be in flight after the last cell
	task automatic drain_pipe();
		wait_cells_out();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] wdata);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= wdata;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, wdata);
		n_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [RANGE_W-1:0] pick_range();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return RANGE_W'($urandom_range(0, 12000));
		if (r < 85)
			return RANGE_W'($urandom_range(0, 65535));
		if (r < 95)
			return $urandom_range(0, 1) ? '1 : '0;
		return RANGE_W'($urandom_range(0, 300));
	endfunction

	function automatic logic [BEAM_W-1:0] pick_beam();
		// mostly a running scan, the rest scattered
		if ($urandom_range(0, 99) < 70) begin
			scan_pos = scan_pos + 1'b1;
			return scan_pos;
		end
		return BEAM_W'($urandom);
	endfunction

	task automatic random_geometry(input bit wild);
		logic [CFG_DATA_W-1:0] px, py, hd, st, sp, sc, ox, oy;
		if (!wild) begin
			px = CFG_DATA_W'(int'($urandom_range(0, 40000)) - 20000);
			py = CFG_DATA_W'(int'($urandom_range(0, 40000)) - 20000);
			hd = CFG_DATA_W'($urandom);
			st = CFG_DATA_W'($urandom);
			sp = $urandom_range(0, 1) ? CFG_DATA_W'($urandom)
				: {8'($urandom), 16'($urandom_range(0, 400))};
			sc = CFG_DATA_W'(32'd16777216 / $urandom_range(5, 200));
			ox = {8'($urandom), 16'($urandom_range(0, 1023))};
			oy = {8'($urandom), 16'($urandom_range(0, 1023))};
		end else begin
			case ($urandom_range(0, 2))
				0: px = 24'h800000;
				1: px = 24'h7FFFFF;
				default: px = CFG_DATA_W'($urandom);
			endcase
			case ($urandom_range(0, 2))
				0: py = 24'h800000;
				1: py = 24'h7FFFFF;
				default: py = CFG_DATA_W'(int'($urandom_range(0, 2000)) - 1000);
			endcase
			hd = {8'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
			st = {8'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
			sp = {8'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom)};
			case ($urandom_range(0, 3))
				0: sc = 24'd1;
				1: sc = 24'hFFFFFF;
				2: sc = 24'd0;
				default: sc = CFG_DATA_W'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0: ox = {8'($urandom), 16'h8000};
				1: ox = {8'($urandom), 16'h7FFF};
				2: ox = {8'($urandom), 16'd1023};
				default: ox = {8'($urandom), 16'd0};
			endcase
			case ($urandom_range(0, 3))
				0: oy = {8'($urandom), 16'h8000};
				1: oy = {8'($urandom), 16'h7FFF};
				2: oy = {8'($urandom), 16'd1023};
				default: oy = {8'($urandom), 16'd0};
			endcase
		end
		write_reg(REG_POSE_X, px);
		write_reg(REG_POSE_Y, py);
		write_reg(REG_HEADING, hd);
		write_reg(REG_ANG_BASE, st);
		write_reg(REG_ANG_PITCH, sp);
		write_reg(REG_CELL_SCALE, sc);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
				CFG_DATA_W'($urandom));
	endtask

	// output side: random stalls unless the run is in a calm stretch
	initial begin
		int hold;
		bit rdy;
		hold = 0;
		rdy  = 1'b0;
		cell_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				rdy = 1'b1;
			end else if (hold == 0) begin
				rdy  = !rdy;
				hold = rdy ? $urandom_range(1, 20) : pick_gap();
			end else begin
				hold--;
			end
			cell_ch.ready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cell_ch.valid && cell_ch.ready) begin
			if (cells_due.size() == 0) begin
				report_mismatch("cell with nothing due, cell_x", int'(cell_ch.cell_x), -1);
			end else begin
				want_cell = cells_due.pop_front();
				n_cells++;
				if (cell_ch.cell_x !== want_cell.cell_x)
					report_mismatch("cell_x", int'(cell_ch.cell_x), int'(want_cell.cell_x));
				if (cell_ch.cell_y !== want_cell.cell_y)
					report_mismatch("cell_y", int'(cell_ch.cell_y), int'(want_cell.cell_y));
			end
		end
	end

	task automatic test_reset_defaults();
		send_beam('0, '0);
		send_beam('0, 16'd1000);
		send_beam('1, '1);
		send_beam(11'd1000, 16'd20000);
	endtask

	// quarter-turn steps land on the axes, with full range at the map edges
	task automatic test_quadrant_axes();
		drain_pipe();
		write_reg(REG_ANG_PITCH, 24'd16384);
		write_reg(REG_CELL_SCALE, 24'd131072);
		send_beam(11'd0, '1);
		send_beam(11'd1, '1);
		send_beam(11'd2, '1);
		send_beam(11'd3, '1);
		send_beam('1, '0);
	endtask

	task automatic test_angle_wrap();
		drain_pipe();
		write_reg(REG_ANG_BASE, 24'h00FFFF);
		write_reg(REG_HEADING, 24'hFFFFFF);
		write_reg(REG_ANG_PITCH, 24'h5AFFFF);
		write_reg(REG_CELL_SCALE, 24'd335544);
		send_beam('1, 16'd6000);
		send_beam(11'd1, 16'd6000);
		send_beam(11'd0, 16'd6000);
	endtask

	// angles between table points exercise the interpolation
	task automatic test_interpolation();
		drain_pipe();
		write_reg(REG_ANG_BASE, 24'd0);
		write_reg(REG_HEADING, 24'd0);
		write_reg(REG_ANG_PITCH, 24'd7);
		send_beam(11'd1, 16'd20000);
		send_beam(11'd37, 16'd20000);
		send_beam(11'd255, 16'd20000);
		send_beam('1, 16'd20000);
	endtask

	task automatic test_map_edges();
		drain_pipe();
		// zero scale puts every hit on the origin cell
		write_reg(REG_CELL_SCALE, 24'd0);
		write_reg(REG_ORIGIN_X, 24'hAB03FF);
		write_reg(REG_ORIGIN_Y, 24'h120000);
		send_beam(BEAM_W'($urandom), '1);
		send_beam(BEAM_W'($urandom), '1);
		drain_pipe();
		// spare register indexes must leave the geometry alone
		write_reg(CFG_IDX_W'(FIRST_SPARE_REG), 24'hFFFFFF);
		write_reg(CFG_IDX_W'(LAST_SPARE_REG), 24'h000000);
		send_beam('0, '0);
		drain_pipe();
		write_reg(REG_ORIGIN_X, 24'h008000);
		send_beam('0, '0);
		drain_pipe();
		write_reg(REG_ORIGIN_X, 24'd512);
		write_reg(REG_CELL_SCALE, 24'hFFFFFF);
		write_reg(REG_POSE_X, 24'h800000);
		send_beam('0, '1);
	endtask

	task automatic test_random_scans();
		int pause_at;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_pipe();
			random_geometry(ph % 3 == 2);
			scan_pos = BEAM_W'($urandom);
			pause_at = $urandom_range(10, PHASE_BEAMS - 10);
			for (int k = 0; k < PHASE_BEAMS; k++) begin
				if (k == pause_at)
					wait_cells_out();
				send_beam(pick_beam(), pick_range());
			end
		end
	endtask

	task automatic test_back_to_back();
		drain_pipe();
		random_geometry(1'b0);
		calm = 1'b1;
		for (int k = 0; k < 60; k++)
			send_beam(pick_beam(), pick_range());
		calm = 1'b0;
	endtask

	task automatic finish_run();
		int waited;
		waited = 0;
		beam_idle();
		while (cells_due.size() != 0 && waited < END_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (cells_due.size() != 0)
			report_mismatch("cells never delivered", 0, cells_due.size());
		$display("run: %0d beams in, %0d cells checked, %0d beams off the map",
			n_beams, n_cells, n_missed);
		$display("run: %0d register writes incl. spare indexes and extreme geometry",
			n_writes);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	endtask

	initial begin
		arst_n             = 1'b0;
		calm               = 1'b0;
		beam_ch.valid      = 1'b0;
		beam_ch.beam_index = '0;
		beam_ch.range_mm   = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;
		scan_pos           = '0;
		n_beams  = 0;
		n_missed = 0;
		n_cells  = 0;
		n_writes = 0;
		n_errors = 0;
		reset_geometry();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_quadrant_axes();
		test_angle_wrap();
		test_interpolation();
		test_map_edges();
		test_random_scans();
		test_back_to_back();
		finish_run();
	end

endmodule
